/* src/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 64;
  localparam int DEF_COUNT_BITS = 16;

  localparam int FIELD_W    = 64;
  localparam int CMD_W      = 2;
  localparam int CAP_W      = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_PUT    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_POLICY   = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             policy;
    logic [CAP_W-1:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] read_value;
    logic               evicted;
    logic [FIELD_W-1:0] evicted_key;
  } rsp_t;

endpackage

/* src/lkvc_if.sv */
interface lkvc_req_if;
  logic                        valid;
  logic                        ready;
  logic [lkvc_pkg::CMD_W-1:0]   cmd;
  logic [lkvc_pkg::FIELD_W-1:0] lookup_key;
  logic [lkvc_pkg::FIELD_W-1:0] write_value;

  modport source (output valid, cmd, lookup_key, write_value, input ready);
  modport sink (input valid, cmd, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [lkvc_pkg::FIELD_W-1:0] read_value;
  logic                        evicted;
  logic [lkvc_pkg::FIELD_W-1:0] evicted_key;

  modport source (output valid, found, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

/* src/lru_lfu_key_value_cache.sv */
// Path: a request accepted into the request register is looked up from there and its
//   response is captured in the result register, which holds it until it is taken.
// Throughput: one request per cycle while responses are taken (a held response stalls
//   the request register), set by the combinational key compare across all entries
//   and the victim selection tree feeding the result register.
// Reset (synchronous, active low): all entries invalid, counts and ranks zero,
//   policy LRU, capacity 16; no clearing pass, requests are taken right away.
module lru_lfu_key_value_cache #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS,
  parameter int COUNT_BITS = lkvc_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lkvc_req_if.sink                        in_req,
  lkvc_rsp_if.source                      out_rsp,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import lkvc_pkg::*;

  cfg_t cfg;
  rsp_t rsp, rsp_r;

  logic                  in_valid_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  out_valid_r;
  logic                  advance;
  logic                  in_fire;

  lkvc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lkvc_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cmd   (cmd_r),
    .key   (key_r),
    .value (value_r),
    .cfg   (cfg),
    .rsp   (rsp)
  );

  // advance the held request whenever the result register is free or draining
  assign advance      = in_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !in_valid_r || advance;
  assign in_fire      = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_req.cmd;
      key_r   <= in_req.lookup_key[KEY_BITS-1:0];
      value_r <= in_req.write_value[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) rsp_r <= rsp;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.found       = rsp_r.found;
  assign out_rsp.read_value  = rsp_r.read_value;
  assign out_rsp.evicted     = rsp_r.evicted;
  assign out_rsp.evicted_key = rsp_r.evicted_key;

endmodule

/* src/lkvc_cfg.sv */
module lkvc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [lkvc_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [lkvc_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output lkvc_pkg::cfg_t                    cfg
);
  import lkvc_pkg::*;

  logic             policy_r, policy_nxt;
  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic             wr_en;
  reg_idx_t         reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    policy_nxt   = policy_r;
    capacity_nxt = capacity_r;
    cfg_prdata   = '0;
    unique case (reg_idx)
      REG_POLICY: begin
        cfg_prdata = APB_DATA_W'(policy_r);
        if (wr_en) policy_nxt = cfg_pwdata[0];
      end
      REG_CAPACITY: begin
        cfg_prdata = APB_DATA_W'(capacity_r);
        if (wr_en) capacity_nxt = cfg_pwdata[CAP_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= 1'b0;
      capacity_r <= CAP_RESET;
    end else begin
      policy_r   <= policy_nxt;
      capacity_r <= capacity_nxt;
    end
  end

  assign cfg.policy   = policy_r;
  assign cfg.capacity = capacity_r;

endmodule

/* src/lkvc_victim.sv */
module lkvc_victim #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lkvc_pkg::DEF_COUNT_BITS,
  parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int RANK_W     = IDX_W
) (
  input  logic                                 policy,
  input  logic [ENTRIES-1:0]                   valid,
  input  logic [ENTRIES-1:0][COUNT_BITS-1:0]   count,
  input  logic [ENTRIES-1:0][RANK_W-1:0]       rank,
  output logic [IDX_W-1:0]                     victim
);
  import lkvc_pkg::*;

  localparam int LEAVES  = 1 << $clog2(ENTRIES);
  localparam int SCORE_W = COUNT_BITS + RANK_W;

  logic [2*LEAVES-1:0]              node_vld;
  logic [2*LEAVES-1:0][SCORE_W-1:0] node_score;
  logic [2*LEAVES-1:0][IDX_W-1:0]   node_idx;

  // highest score wins: lowest count first under LFU, then oldest rank
  always_comb begin
    node_vld   = '0;
    node_score = '0;
    node_idx   = '0;
    for (int k = 0; k < LEAVES; k++) begin
      if (k < ENTRIES) begin
        node_vld[LEAVES+k]   = valid[k];
        node_score[LEAVES+k] = policy ? {~count[k], rank[k]} : {{COUNT_BITS{1'b0}}, rank[k]};
        node_idx[LEAVES+k]   = IDX_W'(k);
      end
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      if (node_vld[2*i+1] &&
          (!node_vld[2*i] || node_score[2*i+1] > node_score[2*i])) begin
        node_vld[i]   = 1'b1;
        node_score[i] = node_score[2*i+1];
        node_idx[i]   = node_idx[2*i+1];
      end else begin
        node_vld[i]   = node_vld[2*i];
        node_score[i] = node_score[2*i];
        node_idx[i]   = node_idx[2*i];
      end
    end
  end

  assign victim = node_idx[1];

endmodule

/* src/lkvc_store.sv */
module lkvc_store #(
  parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS,
  parameter int COUNT_BITS = lkvc_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [lkvc_pkg::CMD_W-1:0]        cmd,
  input  logic [KEY_BITS-1:0]              key,
  input  logic [VALUE_BITS-1:0]            value,
  input  lkvc_pkg::cfg_t                   cfg,
  output lkvc_pkg::rsp_t                   rsp
);
  import lkvc_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]                 valid_r, valid_nxt;
  logic [ENTRIES-1:0][KEY_BITS-1:0]   key_r, key_nxt;
  logic [ENTRIES-1:0][VALUE_BITS-1:0] value_r, value_nxt;
  logic [ENTRIES-1:0][COUNT_BITS-1:0] count_r, count_nxt;
  logic [ENTRIES-1:0][RANK_W-1:0]     rank_r, rank_nxt;

  logic             hit;
  logic [IDX_W-1:0] hit_idx, free_idx, victim_idx, slot;
  logic [CNT_W-1:0] nvalid, cap_eff;
  logic [RANK_W-1:0] r_ref;
  logic             is_get, is_put, is_del, cap_ok;
  logic             do_touch, do_del, do_ins, do_evict;

  lkvc_victim #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W),
    .RANK_W     (RANK_W)
  ) u_victim (
    .policy (cfg.policy),
    .valid  (valid_r),
    .count  (count_r),
    .rank   (rank_r),
    .victim (victim_idx)
  );

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (valid_r[j] && key_r[j] == key) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (!valid_r[j]) free_idx = IDX_W'(j);
    end
  end

  assign nvalid  = CNT_W'($countones(valid_r));
  assign cap_eff = (int'(cfg.capacity) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(cfg.capacity);
  assign cap_ok  = cap_eff != '0;

  always_comb begin
    is_get = 1'b0;
    is_put = 1'b0;
    is_del = 1'b0;
    unique case (cmd)
      CMD_GET:    is_get = 1'b1;
      CMD_PUT:    is_put = 1'b1;
      CMD_DELETE: is_del = 1'b1;
      default: ;
    endcase
  end

  assign do_touch = hit && (is_get || (is_put && cap_ok));
  assign do_del   = hit && is_del;
  assign do_ins   = !hit && is_put && cap_ok;
  assign do_evict = do_ins && (nvalid >= cap_eff);
  assign slot     = do_evict ? victim_idx : free_idx;
  assign r_ref    = do_evict ? rank_r[victim_idx] : rank_r[hit_idx];

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    for (int j = 0; j < ENTRIES; j++) begin
      if (do_touch) begin
        if (IDX_W'(j) == hit_idx) begin
          rank_nxt[j] = '0;
          if (count_r[j] != '1) count_nxt[j] = count_r[j] + 1'b1;
          if (is_put) value_nxt[j] = value;
        end else if (valid_r[j] && rank_r[j] < r_ref) begin
          rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end else if (do_del) begin
        if (IDX_W'(j) == hit_idx) begin
          valid_nxt[j] = 1'b0;
          count_nxt[j] = '0;
          rank_nxt[j]  = '0;
        end else if (valid_r[j] && rank_r[j] > r_ref) begin
          rank_nxt[j] = rank_r[j] - 1'b1;
        end
      end else if (do_ins) begin
        if (IDX_W'(j) == slot) begin
          valid_nxt[j] = 1'b1;
          key_nxt[j]   = key;
          value_nxt[j] = value;
          count_nxt[j] = COUNT_BITS'(1);
          rank_nxt[j]  = '0;
        end else if (valid_r[j]) begin
          if (do_evict && rank_r[j] > r_ref) rank_nxt[j] = rank_r[j];
          else rank_nxt[j] = rank_r[j] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      rank_r  <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_r   <= key_nxt;
      value_r <= value_nxt;
    end
  end

  always_comb begin
    rsp.found       = hit && (is_get || is_put || is_del);
    rsp.read_value  = (is_get && hit) ? FIELD_W'(value_r[hit_idx]) : '0;
    rsp.evicted     = do_evict;
    rsp.evicted_key = do_evict ? FIELD_W'(key_r[victim_idx]) : '0;
  end

  a_evict_keeps_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    en && do_evict |=> $countones(valid_r) == $past($countones(valid_r)))
    else $error("eviction changed occupancy");

  a_insert_grows_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    en && do_ins && !do_evict |=> $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("insert into free slot did not grow occupancy");

  a_insert_is_newest: assert property (@(posedge clk) disable iff (!rst_n)
    en && do_ins |=> valid_r[$past(slot)] && rank_r[$past(slot)] == '0)
    else $error("inserted entry is not valid with rank zero");

  a_lru_victim_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    en && do_evict && !cfg.policy |-> CNT_W'(rank_r[victim_idx]) == nvalid - 1'b1)
    else $error("LRU victim is not the oldest entry");

endmodule

/* bench/tb_lru_lfu_key_value_cache.sv */
`timescale 1ns / 1ps

module tb_lru_lfu_key_value_cache;
  import lkvc_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;
  localparam int IDLE_LIMIT = 1000;
  localparam int LONG_HOLD = 120;
  localparam int HOT_GETS = 12;
  localparam int NUM_PHASES = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam rsp_t NO_HIT = '0;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    reg_sel;
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] data;
    bit          lit;
    rsp_t        want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();

  lru_lfu_key_value_cache dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_if),
    .out_rsp     (rsp_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the cache contents and settings
  logic        m_policy;
  logic [4:0]  m_cap;
  logic        m_valid [ENTRIES];
  logic [63:0] m_key [ENTRIES];
  logic [63:0] m_val [ENTRIES];
  logic [15:0] m_count [ENTRIES];
  logic [3:0]  m_rank [ENTRIES];

  rsp_t rsp_due_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_rsp_long = 1'b0;
  logic [63:0] key_pool [24];

  int phase_policy [NUM_PHASES] = '{1, 1, 0, 0, 1, 0, 1, 0};
  int phase_cap [NUM_PHASES] = '{16, 4, 31, 1, 17, 0, 2, 16};
  int phase_items [NUM_PHASES] = '{300, 250, 300, 150, 300, 60, 200, 440};

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  function automatic void touch_entry(int i);
    logic [3:0] r;
    r = m_rank[i];
    for (int j = 0; j < ENTRIES; j++)
      if (m_valid[j] && j != i && m_rank[j] < r) m_rank[j]++;
    m_rank[i] = '0;
    if (m_count[i] != 16'hFFFF) m_count[i]++;
  endfunction

  function automatic void drop_entry(int i);
    logic [3:0] r;
    r = m_rank[i];
    for (int j = 0; j < ENTRIES; j++)
      if (m_valid[j] && j != i && m_rank[j] > r) m_rank[j]--;
    m_valid[i] = 1'b0;
    m_count[i] = '0;
    m_rank[i] = '0;
  endfunction

  function automatic rsp_t apply_cache_op(logic [1:0] op, logic [63:0] key, logic [63:0] data);
    rsp_t r;
    int hit;
    int held;
    int slot;
    int lim;
    bit better;
    r = '0;
    hit = -1;
    held = 0;
    slot = -1;
    lim = (m_cap > ENTRIES) ? ENTRIES : int'(m_cap);
    for (int j = 0; j < ENTRIES; j++) begin
      if (m_valid[j]) begin
        held++;
        if (m_key[j] == key) hit = j;
      end
    end
    case (op)
      CMD_GET: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.read_value = m_val[hit];
          touch_entry(hit);
        end
      end
      CMD_PUT: begin
        r.found = (hit >= 0);
        if (lim != 0 && hit >= 0) begin
          m_val[hit] = data;
          touch_entry(hit);
        end else if (lim != 0) begin
          if (held >= lim) begin
            for (int j = 0; j < ENTRIES; j++) begin
              if (m_valid[j]) begin
                if (slot < 0) better = 1'b1;
                else if (m_policy)
                  better = (m_count[j] < m_count[slot]) ||
                           (m_count[j] == m_count[slot] && m_rank[j] > m_rank[slot]);
                else better = (m_rank[j] > m_rank[slot]);
                if (better) slot = j;
              end
            end
            if (slot >= 0) begin
              r.evicted = 1'b1;
              r.evicted_key = m_key[slot];
              drop_entry(slot);
            end
          end else begin
            for (int j = 0; j < ENTRIES; j++)
              if (!m_valid[j] && slot < 0) slot = j;
          end
          if (slot >= 0) begin
            for (int j = 0; j < ENTRIES; j++)
              if (m_valid[j]) m_rank[j]++;
            m_valid[slot] = 1'b1;
            m_key[slot] = key;
            m_val[slot] = data;
            m_count[slot] = 16'd1;
            m_rank[slot] = '0;
          end
        end
      end
      CMD_DELETE: begin
        r.found = (hit >= 0);
        if (hit >= 0) drop_entry(hit);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_req(logic [1:0] op, logic [63:0] key, logic [63:0] data,
                          bit lit, rsp_t want);
    int gap;
    rsp_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= op;
    req_if.lookup_key <= key;
    req_if.write_value <= data;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted = apply_cache_op(op, key, data);
    rsp_due_q.push_back(lit ? want : predicted);
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (rsp_due_q.size() != 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_POLICY) m_policy = data[0];
    else m_cap = data[4:0];
  endtask

  initial begin : rsp_sink
    int stall;
    rsp_t want;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_rsp_long) begin
        hold_rsp_long = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      if (rsp_due_q.size() == 0) begin
        flag_mismatch("request with nothing outstanding", rsp_if.read_value, '0);
      end else begin
        want = rsp_due_q.pop_front();
        if (rsp_if.found !== want.found)
          flag_mismatch("found", 64'(rsp_if.found), 64'(want.found));
        if (rsp_if.read_value !== want.read_value)
          flag_mismatch("read_value", rsp_if.read_value, want.read_value);
        if (rsp_if.evicted !== want.evicted)
          flag_mismatch("evicted", 64'(rsp_if.evicted), 64'(want.evicted));
        if (rsp_if.evicted_key !== want.evicted_key)
          flag_mismatch("evicted_key", rsp_if.evicted_key, want.evicted_key);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lru_lfu_key_value_cache failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    dir_row_t dir_rows[$];
    dir_row_t row;
    int pool_n;
    int pick;
    logic [1:0] op;
    logic [63:0] key;
    logic [63:0] sat_key;
    logic [63:0] rival_key;

    rst_n <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.cmd <= CMD_GET;
    req_if.lookup_key <= '0;
    req_if.write_value <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;

    m_policy = 1'b0;
    m_cap = CAP_RESET;
    for (int j = 0; j < ENTRIES; j++) begin
      m_valid[j] = 1'b0;
      m_key[j] = '0;
      m_val[j] = '0;
      m_count[j] = '0;
      m_rank[j] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    for (int j = 2; j < 24; j++) key_pool[j] = {$urandom, $urandom};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h0, 64'h0, 1'b1, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, 64'h0, ALL_ONES, 1'b1, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h0, 64'h0, 1'b1, {1'b1, ALL_ONES, 1'b0, 64'h0}},
      '{ROW_REQ, REG_POLICY, CMD_PUT, ALL_ONES, 64'h0, 1'b1, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, ALL_ONES, ALL_ONES, 1'b1, {1'b1, 64'h0, 1'b0, 64'h0}},
      '{ROW_REQ, REG_POLICY, CMD_UNUSED, ALL_ONES, ALL_ONES, 1'b1, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, 64'h0, 64'h5, 1'b1, {1'b1, 64'h0, 1'b0, 64'h0}},
      '{ROW_REQ, REG_POLICY, CMD_DELETE, ALL_ONES, 64'h0, 1'b1, {1'b1, 64'h0, 1'b0, 64'h0}},
      '{ROW_REQ, REG_POLICY, CMD_DELETE, ALL_ONES, 64'h0, 1'b1, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, ALL_ONES, 64'h0, 1'b1, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h0, 64'h0, 1'b1, {1'b1, 64'h5, 1'b0, 64'h0}},
      '{ROW_CFG, REG_CAPACITY, CMD_GET, 64'h0, 64'd2, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, 64'h1, 64'd11, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, 64'h2, 64'd22, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h1, 64'h0, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, 64'h3, 64'd33, 1'b0, NO_HIT},
      '{ROW_CFG, REG_POLICY, CMD_GET, 64'h0, 64'd1, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h1, 64'h0, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h1, 64'h0, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h3, 64'h0, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, 64'h4, 64'd44, 1'b0, NO_HIT},
      '{ROW_CFG, REG_CAPACITY, CMD_GET, 64'h0, 64'd0, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, 64'h5, 64'd55, 1'b1, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_GET, 64'h1, 64'h0, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_DELETE, 64'h1, 64'h0, 1'b0, NO_HIT},
      '{ROW_CFG, REG_CAPACITY, CMD_GET, 64'h0, 64'd31, 1'b0, NO_HIT},
      '{ROW_REQ, REG_POLICY, CMD_PUT, ALL_ONES, ALL_ONES, 1'b0, NO_HIT},
      '{ROW_CFG, REG_POLICY, CMD_GET, 64'h0, 64'd0, 1'b0, NO_HIT}
    };

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        drain_responses();
        write_reg(row.reg_sel, row.data[31:0]);
      end else begin
        send_req(row.op, row.key, row.data, row.lit, row.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_responses();
      write_reg(REG_POLICY, 32'(phase_policy[p]));
      write_reg(REG_CAPACITY, 32'(phase_cap[p]));
      pool_n = ((phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p]) + 4;
      no_idle = (p == 3);
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 0 && n == 40) hold_rsp_long = 1'b1;
        if (p == 2 && n == 150) drain_responses();
        pick = $urandom_range(0, 99);
        if (pick < 40) op = CMD_GET;
        else if (pick < 80) op = CMD_PUT;
        else if (pick < 95) op = CMD_DELETE;
        else op = CMD_UNUSED;
        if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
        else key = key_pool[$urandom_range(0, pool_n - 1)];
        send_req(op, key, {$urandom, $urandom}, 1'b0, NO_HIT);
      end
    end

    // raise one use count, then show it outranks a lower count under LFU
    drain_responses();
    no_idle = 1'b1;
    write_reg(REG_POLICY, 32'd1);
    write_reg(REG_CAPACITY, 32'd2);
    for (int j = 0; j < ENTRIES; j++)
      if (m_valid[j]) send_req(CMD_DELETE, m_key[j], '0, 1'b0, NO_HIT);
    sat_key = {$urandom, $urandom};
    rival_key = ~sat_key;
    send_req(CMD_PUT, sat_key, {$urandom, $urandom}, 1'b0, NO_HIT);
    for (int n = 0; n < HOT_GETS; n++) send_req(CMD_GET, sat_key, '0, 1'b0, NO_HIT);
    send_req(CMD_PUT, rival_key, {$urandom, $urandom}, 1'b0, NO_HIT);
    for (int n = 0; n < 9; n++) send_req(CMD_GET, rival_key, '0, 1'b0, NO_HIT);
    send_req(CMD_GET, sat_key, '0, 1'b0, NO_HIT);
    send_req(CMD_PUT, sat_key ^ 64'h1, {$urandom, $urandom}, 1'b0, NO_HIT);
    no_idle = 1'b0;

    drain_responses();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_lru_lfu_key_value_cache passed");
    end else begin
      $display("tb_lru_lfu_key_value_cache failed");
    end
    $finish;
  end

endmodule
